// File: hdl/gba_pkg.sv
package gba_pkg;

    // default grid size
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // field widths
    localparam int COORD_W    = 32;
    localparam int VAL_W      = 32;
    localparam int WIDTH_W    = 31;
    localparam int USE_W      = 7;
    localparam int IDX_W      = 6;
    localparam int MEAN_W     = 32;
    localparam int SUM_W      = 48;
    localparam int TALLY_W    = 16;
    localparam int WORD_W     = SUM_W + TALLY_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // shared divider sizes
    localparam int DIV_Q_W   = 48;
    localparam int DIV_R_W   = 31;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LONG_STEPS  = 6'd48;
    localparam logic [DIV_CNT_W-1:0] DIV_SHORT_STEPS = 6'd32;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 16'hFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 3'd4;

    // register reset values
    localparam logic [WIDTH_W-1:0] RST_CELL_WIDTH = 31'd65536;
    localparam logic [USE_W-1:0]   RST_IN_USE     = 7'd64;

    // request and status codes
    localparam logic REQ_ADD        = 1'b0;
    localparam logic REQ_READ       = 1'b1;
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_XGO,
        S_XWAIT,
        S_YGO,
        S_YWAIT,
        S_RDADDR,
        S_UPD,
        S_MGO,
        S_MWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic               long_op;
        logic [DIV_Q_W-1:0] dividend;
        logic [DIV_R_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: hdl/gba_div.sv
module gba_div import gba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_Q_W-1:0]   r_q;
    logic [DIV_R_W-1:0]   r_rem;
    logic [DIV_R_W-1:0]   r_dvs;

    logic [DIV_Q_W-1:0]   n_q;
    logic [DIV_R_W-1:0]   n_rem;
    logic [DIV_R_W:0]     trial;
    logic [DIV_R_W+1:0]   diff;
    logic                 ge;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_q[DIV_Q_W-1]};
        diff  = {1'b0, trial} - {2'b00, r_dvs};
        ge    = ~diff[DIV_R_W+1];
        n_rem = ge ? diff[DIV_R_W-1:0] : trial[DIV_R_W-1:0];
        n_q   = {r_q[DIV_Q_W-2:0], ge};
    end

    // step counter and handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.long_op ? DIV_LONG_STEPS : DIV_SHORT_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.long_op ? i_req.dividend : {i_req.dividend[31:0], 16'h0000};
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

// File: hdl/gba_cell_store.sv
module gba_cell_store import gba_pkg::*; #(
    parameter int DEPTH  = DEF_MAX_COLS * DEF_MAX_ROWS,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/grid_bin_average_top.sv
// grid binning with a per-cell mean
// input channel (i_in_valid / o_in_ready) carries one request item: add a
// sample (req_type 0) or read a cell mean and clear it (req_type 1).
// output channel (o_out_valid / i_out_ready) returns one result item per
// request. config channel (i_cfg_valid / o_cfg_ready) is always ready and
// writes origin_x, origin_y, cell_width, cols_in_use, rows_in_use by index.
// one request at a time; one shared radix-2 divider does every divide, and
// each kind of request takes these steps from acceptance to o_out_valid:
//   add inside the grid: two divides (column, then row), then the cell update
//   add outside the grid (negative offset or zero width): no divide
//   add failing the column check: ends after the first divide, the row check: after the second
//   read of a filled cell: one 48-step divide of sum by count
//   read of an empty cell: no divide; read of one beyond the store: no store access
// o_in_ready returns together with o_out_valid, as the result enters the
// output register, so no new item is taken before then.
// after reset all MAX_ROWS*MAX_COLS cells of the store (4096 by default)
// are swept to zero, one cell a cycle; no item is taken until then.
// results pass through an output register: a stalled receiver holds the
// result steady, the next request runs until its own result is ready and
// then holds the input off.
module grid_bin_average_top import gba_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_req_type,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_sample_value,
    input  logic [IDX_W-1:0]      i_read_row,
    input  logic [IDX_W-1:0]      i_read_col,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_status,
    output logic [IDX_W-1:0]      o_cell_row,
    output logic [IDX_W-1:0]      o_cell_col,
    output logic signed [31:0]    o_cell_mean,
    output logic [TALLY_W-1:0]    o_cell_count,
    // config channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH   = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_RC  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int RC_W    = ($clog2(MAX_RC) > IDX_W) ? $clog2(MAX_RC) : IDX_W;

    // config registers
    logic signed [COORD_W-1:0] r_origin_x;
    logic signed [COORD_W-1:0] r_origin_y;
    logic [WIDTH_W-1:0]        r_cell_width;
    logic [USE_W-1:0]          r_cols;
    logic [USE_W-1:0]          r_rows;

    // sequencer and item registers
    t_state                    r_state, n_state;
    logic [ADDR_W-1:0]         r_clr_addr, n_clr_addr;
    logic                      r_req, n_req;
    logic [VAL_W-1:0]          r_val, n_val;
    logic [31:0]               r_dx, n_dx;
    logic [31:0]               r_dy, n_dy;
    logic [RC_W-1:0]           r_row, n_row;
    logic [RC_W-1:0]           r_col, n_col;
    logic                      r_sum_neg, n_sum_neg;
    logic [SUM_W-1:0]          r_sum_mag, n_sum_mag;
    logic [TALLY_W-1:0]        r_tally, n_tally;

    // result staging and output register
    logic                      r_res_status, n_res_status;
    logic [IDX_W-1:0]          r_res_row, n_res_row;
    logic [IDX_W-1:0]          r_res_col, n_res_col;
    logic [MEAN_W-1:0]         r_res_mean, n_res_mean;
    logic [TALLY_W-1:0]        r_res_count, n_res_count;
    logic                      r_out_valid, n_out_valid;
    logic                      r_o_status, n_o_status;
    logic [IDX_W-1:0]          r_o_row, n_o_row;
    logic [IDX_W-1:0]          r_o_col, n_o_col;
    logic [MEAN_W-1:0]         r_o_mean, n_o_mean;
    logic [TALLY_W-1:0]        r_o_count, n_o_count;

    // datapath signals
    logic signed [COORD_W:0]   dx, dy;
    logic [31:0]               lim_c, lim_r;
    logic                      rd_in_store;
    logic [ADDR_W-1:0]         cell_addr;
    logic [WORD_W-1:0]         mem_rdata;
    logic [TALLY_W-1:0]        rd_tally;
    logic [SUM_W-1:0]          rd_sum;
    logic [SUM_W-1:0]          add_sum;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [WORD_W-1:0]         mem_wdata;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    // config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_cell_width <= RST_CELL_WIDTH;
            r_cols       <= RST_IN_USE;
            r_rows       <= RST_IN_USE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:    r_origin_x   <= i_cfg_data;
                CFG_ORIGIN_Y:    r_origin_y   <= i_cfg_data;
                CFG_CELL_WIDTH:  r_cell_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_COLS_IN_USE: r_cols       <= i_cfg_data[USE_W-1:0];
                CFG_ROWS_IN_USE: r_rows       <= i_cfg_data[USE_W-1:0];
                default: ;
            endcase
        end
    end

    // offsets from the grid origin, exact on 33 bits
    assign dx = {i_pos_x[COORD_W-1], i_pos_x} - {r_origin_x[COORD_W-1], r_origin_x};
    assign dy = {i_pos_y[COORD_W-1], i_pos_y} - {r_origin_y[COORD_W-1], r_origin_y};

    // effective grid limits
    assign lim_c = (32'(r_cols) < 32'(MAX_COLS)) ? 32'(r_cols) : 32'(MAX_COLS);
    assign lim_r = (32'(r_rows) < 32'(MAX_ROWS)) ? 32'(r_rows) : 32'(MAX_ROWS);

    assign rd_in_store = (32'(i_read_row) < 32'(MAX_ROWS)) &&
                         (32'(i_read_col) < 32'(MAX_COLS));

    // cell address and stored word
    assign cell_addr = ADDR_W'(32'(r_row) * 32'(MAX_COLS) + 32'(r_col));
    assign rd_tally  = mem_rdata[TALLY_W-1:0];
    assign rd_sum    = mem_rdata[WORD_W-1:TALLY_W];
    assign add_sum   = rd_sum + {{(SUM_W-VAL_W){r_val[VAL_W-1]}}, r_val};

    gba_cell_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (cell_addr),
        .o_rdata (mem_rdata)
    );

    gba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE);

    // sequencer: next state, datapath loads, store and divider control
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_req        = r_req;
        n_val        = r_val;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_row        = r_row;
        n_col        = r_col;
        n_sum_neg    = r_sum_neg;
        n_sum_mag    = r_sum_mag;
        n_tally      = r_tally;
        n_res_status = r_res_status;
        n_res_row    = r_res_row;
        n_res_col    = r_res_col;
        n_res_mean   = r_res_mean;
        n_res_count  = r_res_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_o_status   = r_o_status;
        n_o_row      = r_o_row;
        n_o_col      = r_o_col;
        n_o_mean     = r_o_mean;
        n_o_count    = r_o_count;
        mem_we       = 1'b0;
        mem_waddr    = cell_addr;
        mem_wdata    = '0;
        div_req          = '0;
        div_req.divisor  = r_cell_width;

        unique case (r_state)
            // sweep the store to zero after reset
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // take an item and sort out the quick cases
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_req_type;
                    n_val = i_sample_value;
                    n_dx  = dx[31:0];
                    n_dy  = dy[31:0];
                    n_row = RC_W'(i_read_row);
                    n_col = RC_W'(i_read_col);
                    n_res_status = STATUS_DONE;
                    n_res_row    = '0;
                    n_res_col    = '0;
                    n_res_mean   = '0;
                    n_res_count  = '0;
                    if (i_req_type == REQ_READ) begin
                        if (rd_in_store) begin
                            n_state = S_RDADDR;
                        end else begin
                            n_res_row = i_read_row;
                            n_res_col = i_read_col;
                            n_state   = S_DONE;
                        end
                    end else if ((r_cell_width == '0) || dx[COORD_W] || dy[COORD_W]) begin
                        n_res_status = STATUS_OUTSIDE;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_XGO;
                    end
                end
            end

            // column = dx / cell_width
            S_XGO: begin
                div_req.start    = 1'b1;
                div_req.long_op  = 1'b0;
                div_req.dividend = {16'h0000, r_dx};
                n_state          = S_XWAIT;
            end

            S_XWAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient[31:0] < lim_c) begin
                        n_col   = RC_W'(div_rsp.quotient[31:0]);
                        n_state = S_YGO;
                    end else begin
                        n_res_status = STATUS_OUTSIDE;
                        n_state      = S_DONE;
                    end
                end
            end

            // row = dy / cell_width
            S_YGO: begin
                div_req.start    = 1'b1;
                div_req.long_op  = 1'b0;
                div_req.dividend = {16'h0000, r_dy};
                n_state          = S_YWAIT;
            end

            S_YWAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient[31:0] < lim_r) begin
                        n_row   = RC_W'(div_rsp.quotient[31:0]);
                        n_state = S_RDADDR;
                    end else begin
                        n_res_status = STATUS_OUTSIDE;
                        n_state      = S_DONE;
                    end
                end
            end

            // store read in flight
            S_RDADDR: begin
                n_state = S_UPD;
            end

            // accumulate or read-and-clear the cell
            S_UPD: begin
                n_res_status = STATUS_DONE;
                n_res_row    = r_row[IDX_W-1:0];
                n_res_col    = r_col[IDX_W-1:0];
                n_res_mean   = '0;
                if (r_req == REQ_ADD) begin
                    if (rd_tally != TALLY_MAX) begin
                        mem_we      = 1'b1;
                        mem_wdata   = {add_sum, rd_tally + 1'b1};
                        n_res_count = rd_tally + 1'b1;
                    end else begin
                        n_res_count = rd_tally;
                    end
                    n_state = S_DONE;
                end else begin
                    mem_we      = 1'b1;
                    mem_wdata   = '0;
                    n_res_count = rd_tally;
                    n_sum_neg   = rd_sum[SUM_W-1];
                    n_sum_mag   = rd_sum[SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;
                    n_tally     = rd_tally;
                    n_state     = (rd_tally == '0) ? S_DONE : S_MGO;
                end
            end

            // mean = sum / count, toward zero
            S_MGO: begin
                div_req.start    = 1'b1;
                div_req.long_op  = 1'b1;
                div_req.dividend = r_sum_mag;
                div_req.divisor  = {{(DIV_R_W-TALLY_W){1'b0}}, r_tally};
                n_state          = S_MWAIT;
            end

            S_MWAIT: begin
                if (div_rsp.done) begin
                    n_res_mean = r_sum_neg ? (~div_rsp.quotient[MEAN_W-1:0] + 1'b1)
                                           : div_rsp.quotient[MEAN_W-1:0];
                    n_state    = S_DONE;
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_row     = r_res_row;
                    n_o_col     = r_res_col;
                    n_o_mean    = r_res_mean;
                    n_o_count   = r_res_count;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_val        <= n_val;
        r_dx         <= n_dx;
        r_dy         <= n_dy;
        r_row        <= n_row;
        r_col        <= n_col;
        r_sum_neg    <= n_sum_neg;
        r_sum_mag    <= n_sum_mag;
        r_tally      <= n_tally;
        r_res_status <= n_res_status;
        r_res_row    <= n_res_row;
        r_res_col    <= n_res_col;
        r_res_mean   <= n_res_mean;
        r_res_count  <= n_res_count;
        r_o_status   <= n_o_status;
        r_o_row      <= n_o_row;
        r_o_col      <= n_o_col;
        r_o_mean     <= n_o_mean;
        r_o_count    <= n_o_count;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_cell_row   = r_o_row;
    assign o_cell_col   = r_o_col;
    assign o_cell_mean  = r_o_mean;
    assign o_cell_count = r_o_count;

    // divider is never restarted while it is still working
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a divide result only arrives in a state that waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_XWAIT || r_state == S_YWAIT ||
                          r_state == S_MWAIT))
        else $error("divide result outside a wait state");

    // the store is written only by the sweep or the cell update
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_UPD))
        else $error("unexpected store write");

    // a skipped sample reports an empty cell
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == STATUS_OUTSIDE) |->
            (r_res_count == '0 && r_res_mean == '0 && r_res_row == '0 &&
             r_res_col == '0))
        else $error("skipped sample with nonzero result");

endmodule

// File: dv/tb_grid_bin_average_top.sv
module tb_grid_bin_average_top;
    import gba_pkg::*;

    localparam int     NCOL      = DEF_MAX_COLS;
    localparam int     NROW      = DEF_MAX_ROWS;
    localparam int     LONG_HOLD = 400;
    localparam int     SETTLE    = 8;
    localparam int     TAIL      = 100;
    localparam longint RUN_LIMIT = 6_000_000;
    localparam longint I32_MIN   = -64'sd2147483648;
    localparam longint I32_MAX   = 64'sd2147483647;
    // index with no register behind it, writes are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [VAL_W-1:0]   value;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
    } t_bin_req;

    typedef struct packed {
        logic                     status;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [MEAN_W-1:0] mean;
        logic [TALLY_W-1:0]       count;
    } t_bin_res;

    // block ports
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  i_req_type     = REQ_ADD;
    logic signed [31:0]    i_pos_x        = '0;
    logic signed [31:0]    i_pos_y        = '0;
    logic signed [31:0]    i_sample_value = '0;
    logic [IDX_W-1:0]      i_read_row     = '0;
    logic [IDX_W-1:0]      i_read_col     = '0;
    logic                  i_out_ready    = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_status;
    logic [IDX_W-1:0]      o_cell_row;
    logic [IDX_W-1:0]      o_cell_col;
    logic signed [31:0]    o_cell_mean;
    logic [TALLY_W-1:0]    o_cell_count;
    logic                  o_cfg_ready;

    // shadow grid settings and cell store
    longint grid_org_x = 0;
    longint grid_org_y = 0;
    longint grid_width = 65536;
    int     grid_cols  = 64;
    int     grid_rows  = 64;
    longint cell_sum_m   [NCOL*NROW];
    int     cell_tally_m [NCOL*NROW];

    t_bin_res           expected_bins [$];
    logic [2*IDX_W-1:0] recent_cells  [$];

    int mismatches = 0;
    int n_checked  = 0;
    int n_adds     = 0;
    int n_reads    = 0;
    int n_outside  = 0;
    int n_settings = 0;
    bit quiet_tail    = 1'b0;
    bit long_hold_req = 1'b0;

    grid_bin_average_top #(
        .MAX_COLS(NCOL),
        .MAX_ROWS(NROW)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_req_type(i_req_type),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_sample_value(i_sample_value),
        .i_read_row(i_read_row),
        .i_read_col(i_read_col),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_cell_row(o_cell_row),
        .o_cell_col(o_cell_col),
        .o_cell_mean(o_cell_mean),
        .o_cell_count(o_cell_count),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // floor of (pos - org) / w, rounded toward minus infinity
    function automatic longint floor_bin(longint pos, longint org, longint w);
        longint d;
        longint q;
        d = pos - org;
        q = d / w;
        if ((d % w) != 0 && d < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // expected result of one request, updating the shadow store
    function automatic t_bin_res predict_bin(t_bin_req rq);
        t_bin_res res;
        longint   c;
        longint   r;
        longint   lim_c;
        longint   lim_r;
        longint   q;
        int       k;
        bit       hit;
        res = '0;
        c   = 0;
        r   = 0;
        hit = 1'b0;
        if (rq.req_type == REQ_ADD) begin
            n_adds++;
            lim_c = (grid_cols < NCOL) ? grid_cols : NCOL;
            lim_r = (grid_rows < NROW) ? grid_rows : NROW;
            if (grid_width != 0) begin
                c   = floor_bin($signed(rq.pos_x), grid_org_x, grid_width);
                r   = floor_bin($signed(rq.pos_y), grid_org_y, grid_width);
                hit = (c >= 0) && (r >= 0) && (c < lim_c) && (r < lim_r);
            end
            if (!hit) begin
                res.status = STATUS_OUTSIDE;
                n_outside++;
            end else begin
                k = int'(r * NCOL + c);
                // saturated cell keeps its count and sum
                if (cell_tally_m[k] < int'(TALLY_MAX)) begin
                    cell_tally_m[k]++;
                    cell_sum_m[k] += longint'($signed(rq.value));
                end
                res.status = STATUS_DONE;
                res.row    = r[IDX_W-1:0];
                res.col    = c[IDX_W-1:0];
                res.count  = cell_tally_m[k][TALLY_W-1:0];
            end
        end else begin
            n_reads++;
            res.status = STATUS_DONE;
            res.row    = rq.row;
            res.col    = rq.col;
            if (rq.row < NROW && rq.col < NCOL) begin
                k         = rq.row * NCOL + rq.col;
                res.count = cell_tally_m[k][TALLY_W-1:0];
                if (cell_tally_m[k] > 0) begin
                    q        = cell_sum_m[k] / longint'(cell_tally_m[k]);
                    res.mean = q[MEAN_W-1:0];
                end
                cell_sum_m[k]   = 0;
                cell_tally_m[k] = 0;
            end
        end
        return res;
    endfunction

    // request builders, unused fields carry random bits
    function automatic t_bin_req add_req(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] v);
        t_bin_req rq;
        rq          = '0;
        rq.req_type = REQ_ADD;
        rq.pos_x    = x;
        rq.pos_y    = y;
        rq.value    = v;
        rq.row      = IDX_W'($urandom);
        rq.col      = IDX_W'($urandom);
        return rq;
    endfunction

    function automatic t_bin_req read_req(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
        t_bin_req rq;
        rq          = '0;
        rq.req_type = REQ_READ;
        rq.pos_x    = $urandom;
        rq.pos_y    = $urandom;
        rq.value    = $urandom;
        rq.row      = r;
        rq.col      = c;
        return rq;
    endfunction

    // a coordinate inside cell idx along one axis, random if it cannot be formed
    function automatic logic signed [31:0] coord_in_cell(longint org, longint idx);
        longint p;
        if (grid_width == 0) begin
            return $urandom;
        end
        p = org + idx * grid_width + longint'($urandom_range(0, 32'(grid_width - 1)));
        if (p < I32_MIN || p > I32_MAX) begin
            return $urandom;
        end
        return p[31:0];
    endfunction

    // mostly well-aimed samples and reads of recently hit cells, some noise
    function automatic t_bin_req random_req();
        t_bin_req          rq;
        longint            c;
        longint            r;
        longint            lim_c;
        longint            lim_r;
        int                sel;
        logic signed [31:0] v;
        lim_c = (grid_cols < NCOL) ? grid_cols : NCOL;
        lim_r = (grid_rows < NROW) ? grid_rows : NROW;
        sel   = $urandom_range(0, 9);
        if ($urandom_range(0, 9) < 3) begin
            rq = read_req(IDX_W'($urandom), IDX_W'($urandom));
            if (sel < 5 && recent_cells.size() > 0) begin
                {rq.row, rq.col} = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
            end else if (sel < 8) begin
                rq.row = IDX_W'($urandom_range(0, 32'((lim_r > 0) ? lim_r - 1 : 0)));
                rq.col = IDX_W'($urandom_range(0, 32'((lim_c > 0) ? lim_c - 1 : 0)));
            end
            return rq;
        end
        v = ($urandom_range(0, 7) == 0) ?
            ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000) : $urandom;
        if (sel == 0) begin
            return add_req($urandom, $urandom, v);
        end
        c = longint'($urandom_range(0, 32'(lim_c + 1))) - 1;
        r = longint'($urandom_range(0, 32'(lim_r + 1))) - 1;
        rq = add_req(coord_in_cell(grid_org_x, c), coord_in_cell(grid_org_y, r), v);
        if (c >= 0 && r >= 0 && c < lim_c && r < lim_r) begin
            recent_cells.push_back({r[IDX_W-1:0], c[IDX_W-1:0]});
            if (recent_cells.size() > 16) begin
                void'(recent_cells.pop_front());
            end
        end
        return rq;
    endfunction

    // send one item, with an occasional gap before it
    task automatic send_req(t_bin_req rq);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_req_type     <= rq.req_type;
        i_pos_x        <= rq.pos_x;
        i_pos_y        <= rq.pos_y;
        i_sample_value <= rq.value;
        i_read_row     <= rq.row;
        i_read_col     <= rq.col;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        expected_bins.push_back(predict_bin(rq));
    endtask

    // drop valid and wait until every result is back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bins.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_ORIGIN_X:    grid_org_x = longint'($signed(data));
            CFG_ORIGIN_Y:    grid_org_y = longint'($signed(data));
            CFG_CELL_WIDTH:  grid_width = longint'(data[WIDTH_W-1:0]);
            CFG_COLS_IN_USE: grid_cols  = int'(data[USE_W-1:0]);
            CFG_ROWS_IN_USE: grid_rows  = int'(data[USE_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // full grid setting, junk in the bits above each register
    task automatic set_grid(logic signed [31:0] ox, logic signed [31:0] oy,
                            logic [WIDTH_W-1:0] w, logic [USE_W-1:0] cols,
                            logic [USE_W-1:0] rows);
        logic [31:0] junk;
        junk = $urandom;
        wait_idle();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_CELL_WIDTH, {junk[31], w});
        write_reg(CFG_COLS_IN_USE, {junk[24:0], cols});
        write_reg(CFG_ROWS_IN_USE, {junk[30:6], rows});
        recent_cells.delete();
        n_settings++;
    endtask

    // reset grid: field extremes, edges of the grid, mean rounding
    task automatic test_directed_defaults();
        send_req(add_req(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF));
        send_req(add_req(32'h0000_FFFF, 32'h0000_FFFF, 32'h7FFF_FFFF));
        send_req(add_req(32'h003F_FFFF, 32'h003F_FFFF, 32'h8000_0000));
        send_req(add_req(32'h0040_0000, 32'h0000_0000, 32'h0000_0001));
        send_req(add_req(32'h0000_0000, 32'h0040_0000, 32'h0000_0001));
        send_req(add_req(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001));
        send_req(add_req(32'h0014_0000, 32'h000A_0000, 32'h1234_5678));
        send_req(add_req(32'h0001_8000, 32'h0001_0000, -32'sd3));
        send_req(add_req(32'h0001_0000, 32'h0001_FFFF, -32'sd2));
        send_req(read_req(6'd0, 6'd0));
        send_req(read_req(6'd63, 6'd63));
        send_req(read_req(6'd1, 6'd1));
        send_req(read_req(6'd0, 6'd0));
    endtask

    // offset origin, limits of the cells in use, zero and oversized settings
    task automatic test_directed_corners();
        set_grid(32'hFFFE_8000, 32'h7FFF_0000, 31'h0000_8000, 7'd3, 7'd1);
        send_req(add_req(32'hFFFE_8000, 32'h7FFF_0000, 32'h0000_0100));
        send_req(add_req(32'hFFFE_7FFF, 32'h7FFF_0000, 32'h0000_0100));
        send_req(add_req(32'hFFFF_FFFF, 32'h7FFF_7FFF, 32'h0000_0200));
        send_req(add_req(32'h0000_0000, 32'h7FFF_0000, 32'h0000_0200));
        send_req(read_req(6'd10, 6'd20));
        send_req(read_req(6'd0, 6'd2));
        set_grid(32'h0, 32'h0, 31'd0, 7'd64, 7'd64);
        send_req(add_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0001));
        set_grid(32'h0, 32'h0, 31'd65536, 7'd0, 7'd64);
        send_req(add_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0001));
        set_grid(32'h0, 32'h0, 31'd65536, 7'd64, 7'd0);
        send_req(add_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0001));
        set_grid(32'h0, 32'h0, 31'd65536, 7'd127, 7'd100);
        send_req(add_req(32'h003F_8000, 32'h003F_8000, 32'h0000_0300));
        send_req(add_req(32'h0040_0000, 32'h0010_0000, 32'h0000_0300));
        wait_idle();
        write_reg(CFG_SPARE, $urandom);
        send_req(read_req(6'd63, 6'd63));
    endtask

    // random requests over a run of grid settings
    task automatic test_random_grids();
        set_grid(32'h0, 32'h0, 31'd65536, 7'd64, 7'd64);
        repeat (140) send_req(random_req());
        set_grid(-$signed({12'd0, 20'($urandom)}), $urandom_range(0, 32'h00FF_FFFF),
                 31'h0000_4000, 7'd5, 7'd4);
        repeat (160) send_req(random_req());
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 7'd64, 7'd64);
        repeat (60) send_req(random_req());
        set_grid($signed($urandom) >>> 1, $signed($urandom) >>> 1, 31'd1, 7'd127, 7'd2);
        repeat (100) send_req(random_req());
        set_grid($signed($urandom) >>> 2, $signed($urandom) >>> 2,
                 WIDTH_W'($urandom_range(32'h100, 32'h0020_0000)),
                 USE_W'($urandom_range(1, 64)), USE_W'($urandom_range(1, 64)));
        repeat (120) send_req(random_req());
    endtask

    // receiver stops for a long stretch while items keep coming
    task automatic test_long_hold();
        long_hold_req = 1'b1;
        repeat (24) send_req(random_req());
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_sender_pause();
        repeat (12) send_req(random_req());
        wait_idle();
        repeat (12) send_req(random_req());
    endtask

    // back-to-back items on a small grid, no idling on either side
    task automatic test_quiet_tail();
        set_grid(32'h0, 32'h0, 31'd65536, 7'd3, 7'd3);
        quiet_tail = 1'b1;
        repeat (120) send_req(random_req());
    endtask

    // result side ready, random stall bursts and the long hold
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 8);
            end
            i_out_ready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    // compare each result item with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_bin_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bins.size() == 0) begin
                report_mismatch("result item with no request pending");
            end else begin
                want = expected_bins.pop_front();
                n_checked++;
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("result %0d status got %0h want %0h",
                                              n_checked, o_status, want.status));
                end
                if (o_cell_row !== want.row) begin
                    report_mismatch($sformatf("result %0d row got %0d want %0d",
                                              n_checked, o_cell_row, want.row));
                end
                if (o_cell_col !== want.col) begin
                    report_mismatch($sformatf("result %0d col got %0d want %0d",
                                              n_checked, o_cell_col, want.col));
                end
                if (o_cell_mean !== want.mean) begin
                    report_mismatch($sformatf("result %0d mean got %h want %h",
                                              n_checked, o_cell_mean, want.mean));
                end
                if (o_cell_count !== want.count) begin
                    report_mismatch($sformatf("result %0d count got %0d want %0d",
                                              n_checked, o_cell_count, want.count));
                end
            end
        end
    end

    // test sequence
    initial begin : run
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_directed_corners();
        test_random_grids();
        test_long_hold();
        test_sender_pause();
        test_quiet_tail();
        wait_idle();
        repeat (TAIL) @(posedge i_clk);
        $display("covered %0d adds (%0d outside the grid) and %0d reads over %0d grid settings",
                 n_adds, n_outside, n_reads, n_settings);
        $display("%0d results compared, %0d mismatches", n_checked, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
